// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the cell scan modules
// both expect clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/gces_pkg.sv -----
package gces_pkg;

  localparam int unsigned DEF_MAX_IMAGE_WIDTH   = 4096;
  localparam int unsigned DEF_MAX_CELLS_PER_ROW = 2048;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned ERR_W    = 18;
  localparam int unsigned SUM_W    = 28;
  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned K_W      = 3;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned THRESH_W = 18;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 18;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam logic [K_W-1:0]      RST_CELL_SIZE = 3'd5;
  localparam logic [DIM_W-1:0]    RST_WIDTH     = 13'd512;
  localparam logic [DIM_W-1:0]    RST_HEIGHT    = 13'd512;
  localparam logic [THRESH_W-1:0] RST_THRESH    = 18'd400;
  localparam logic [K_W-1:0]      K_MIN         = 3'd1;
  localparam logic [K_W-1:0]      K_MAX         = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_SIZE = 8'd0,
    CFG_WIDTH     = 8'd1,
    CFG_HEIGHT    = 8'd2,
    CFG_THRESH    = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  ref_red;
    logic [7:0]  ref_green;
    logic [7:0]  ref_blue;
    logic [7:0]  canvas_red;
    logic [7:0]  canvas_green;
    logic [7:0]  canvas_blue;
  } in_t;

  typedef struct packed {
    logic [11:0] point_x;
    logic [11:0] point_y;
    logic [7:0]  stroke_red;
    logic [7:0]  stroke_green;
    logic [7:0]  stroke_blue;
    logic [27:0] cell_error_sum;
  } out_t;

  // frame geometry as the front end sees it, with k and width already clamped
  typedef struct packed {
    logic [K_W-1:0]   k;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } geom_t;

  // one classified pixel on its way to the back end
  typedef struct packed {
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  base_x;
    logic [COORD_W-1:0]  base_y;
    logic [OFFSET_W-1:0] offset;
    logic [23:0]         colour;
    logic [ERR_W-1:0]    err;
    logic                first;
    logic                last;
  } job_t;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [ERR_W-1:0]    max_err;
    logic [OFFSET_W-1:0] offset;
    logic [23:0]         colour;
  } cell_entry_t;

endpackage

// ----- hw/rtl/grid_cell_error_scan.sv -----
// grid cell error scan: per-cell squared colour error over a raster pixel stream
// throughput: one pixel per cycle, set by the single cell ram read-modify-write
// with the last write forwarded; stalls only when downstream holds the result
// result path: the closing pixel passes the job queue, the stage-2 job register and the output register
// reset: control and config registers return to defaults; the cell ram is not
//   cleared, each cell restarts on its top-left pixel
module grid_cell_error_scan import gces_pkg::*; #(
  parameter int unsigned MAX_IMAGE_WIDTH   = DEF_MAX_IMAGE_WIDTH,
  parameter int unsigned MAX_CELLS_PER_ROW = DEF_MAX_CELLS_PER_ROW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [K_W-1:0]      cell_size_q;
  logic [DIM_W-1:0]    width_q;
  logic [DIM_W-1:0]    height_q;
  logic [THRESH_W-1:0] thresh_q;

  geom_t            geom;
  logic [SUM_W-1:0] limit;
  logic             keep;
  job_t             front_job;
  logic             q_full;
  logic             push;
  logic             head_valid;
  job_t             head_job;
  logic             pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= RST_CELL_SIZE;
      width_q     <= RST_WIDTH;
      height_q    <= RST_HEIGHT;
      thresh_q    <= RST_THRESH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CELL_SIZE: cell_size_q <= cfg_data_i[K_W-1:0];
        CFG_WIDTH:     width_q     <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:    height_q    <= cfg_data_i[DIM_W-1:0];
        CFG_THRESH:    thresh_q    <= cfg_data_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cell_size_q < K_MIN) begin
      geom.k = K_MIN;
    end else if (cell_size_q > K_MAX) begin
      geom.k = K_MAX;
    end else begin
      geom.k = cell_size_q;
    end
    if (32'(width_q) > MAX_IMAGE_WIDTH) begin
      geom.width = DIM_W'(MAX_IMAGE_WIDTH);
    end else begin
      geom.width = width_q;
    end
    geom.height = height_q;
    // threshold times cell area
    limit = SUM_W'(thresh_q) << {geom.k, 1'b0};
  end

  gces_front #(
    .MAX_CELLS_PER_ROW(MAX_CELLS_PER_ROW)
  ) u_front (
    .pix_i (in_data_i),
    .geom_i(geom),
    .keep_o(keep),
    .job_o (front_job)
  );

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full && keep;

  gces_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .job_o  (head_job)
  );

  gces_back #(
    .MAX_CELLS_PER_ROW(MAX_CELLS_PER_ROW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit),
    .head_valid_i(head_valid),
    .head_job_i  (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/gces_ram.sv -----
module gces_ram import gces_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/gces_front.sv -----
module gces_front import gces_pkg::*; #(
  parameter int unsigned MAX_CELLS_PER_ROW = DEF_MAX_CELLS_PER_ROW
) (
  input  in_t   pix_i,
  input  geom_t geom_i,
  output logic  keep_o,
  output job_t  job_o
);

  logic [5:0]         mask6;
  logic [4:0]         mask;
  logic [DIM_W-1:0]   used_w;
  logic [DIM_W-1:0]   used_h;
  logic [COORD_W-1:0] col;
  logic [4:0]         u;
  logic [4:0]         v;
  logic [7:0]         dr;
  logic [7:0]         dg;
  logic [7:0]         db;
  logic [15:0]        sq_r;
  logic [15:0]        sq_g;
  logic [15:0]        sq_b;

  always_comb begin
    mask6  = (6'd1 << geom_i.k) - 6'd1;
    mask   = mask6[4:0];
    used_w = (geom_i.width >> geom_i.k) << geom_i.k;
    used_h = (geom_i.height >> geom_i.k) << geom_i.k;
    col    = pix_i.pixel_x >> geom_i.k;
    u      = pix_i.pixel_x[4:0] & mask;
    v      = pix_i.pixel_y[4:0] & mask;

    // leftover strips, pixels beyond the frame and columns past the store are dropped
    keep_o = ({1'b0, pix_i.pixel_x} < used_w) && ({1'b0, pix_i.pixel_y} < used_h) &&
             (32'(col) < MAX_CELLS_PER_ROW);

    dr = (pix_i.ref_red > pix_i.canvas_red) ? pix_i.ref_red - pix_i.canvas_red
                                            : pix_i.canvas_red - pix_i.ref_red;
    dg = (pix_i.ref_green > pix_i.canvas_green) ? pix_i.ref_green - pix_i.canvas_green
                                                : pix_i.canvas_green - pix_i.ref_green;
    db = (pix_i.ref_blue > pix_i.canvas_blue) ? pix_i.ref_blue - pix_i.canvas_blue
                                              : pix_i.canvas_blue - pix_i.ref_blue;
    sq_r = 16'(dr) * 16'(dr);
    sq_g = 16'(dg) * 16'(dg);
    sq_b = 16'(db) * 16'(db);

    job_o.col    = col;
    job_o.base_x = pix_i.pixel_x & ~{7'd0, mask};
    job_o.base_y = pix_i.pixel_y & ~{7'd0, mask};
    job_o.offset = {v, u};
    job_o.colour = {pix_i.ref_red, pix_i.ref_green, pix_i.ref_blue};
    job_o.err    = ERR_W'(sq_r) + ERR_W'(sq_g) + ERR_W'(sq_b);
    job_o.first  = (u == 5'd0) && (v == 5'd0);
    job_o.last   = (u == mask) && (v == mask);
  end

endmodule

// ----- hw/rtl/gces_queue.sv -----
module gces_queue import gces_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);
  `include "assert_macros.svh"

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  `ASSERT_IMPL(a_no_push_full, push_i, !full_o)
  `ASSERT_IMPL(a_no_pop_empty, pop_i, valid_o)
  `ASSERT_IMPL(a_ptr_count, 1'b1, (wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0])

endmodule

// ----- hw/rtl/gces_back.sv -----
module gces_back import gces_pkg::*; #(
  parameter int unsigned MAX_CELLS_PER_ROW = DEF_MAX_CELLS_PER_ROW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SUM_W-1:0] limit_i,
  input  logic             head_valid_i,
  input  job_t             head_job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o
);
  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(MAX_CELLS_PER_ROW);

  logic                 s2_valid_q, s2_valid_d;
  job_t                 s2_job_q;
  logic                 fwd_valid_q;
  logic [AW-1:0]        fwd_addr_q;
  cell_entry_t          fwd_entry_q;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q;

  logic [AW-1:0]        s2_addr;
  logic [AW-1:0]        head_addr;
  logic [$bits(cell_entry_t)-1:0] ram_rdata;
  cell_entry_t          old_entry;
  cell_entry_t          new_entry;
  logic                 emit;
  logic                 out_free;
  logic                 s2_adv;
  logic                 out_load;
  out_t                 result;

  assign s2_addr   = s2_job_q.col[AW-1:0];
  assign head_addr = head_job_i.col[AW-1:0];

  gces_ram #(
    .WIDTH($bits(cell_entry_t)),
    .DEPTH(MAX_CELLS_PER_ROW)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (s2_adv),
    .waddr_i(s2_addr),
    .wdata_i(new_entry),
    .re_i   (pop_o),
    .raddr_i(head_addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    // the write issued alongside our read is not yet in the ram output
    old_entry = (fwd_valid_q && (fwd_addr_q == s2_addr)) ? fwd_entry_q
                                                         : cell_entry_t'(ram_rdata);
    if (s2_job_q.first) begin
      new_entry.sum     = SUM_W'(s2_job_q.err);
      new_entry.max_err = s2_job_q.err;
      new_entry.offset  = s2_job_q.offset;
      new_entry.colour  = s2_job_q.colour;
    end else begin
      new_entry     = old_entry;
      new_entry.sum = old_entry.sum + SUM_W'(s2_job_q.err);
      if (s2_job_q.err > old_entry.max_err) begin
        new_entry.max_err = s2_job_q.err;
        new_entry.offset  = s2_job_q.offset;
        new_entry.colour  = s2_job_q.colour;
      end
    end

    emit = s2_job_q.last && (new_entry.sum > limit_i);

    result.point_x        = s2_job_q.base_x + COORD_W'(new_entry.offset[4:0]);
    result.point_y        = s2_job_q.base_y + COORD_W'(new_entry.offset[9:5]);
    result.stroke_red     = new_entry.colour[23:16];
    result.stroke_green   = new_entry.colour[15:8];
    result.stroke_blue    = new_entry.colour[7:0];
    result.cell_error_sum = new_entry.sum;

    out_free    = !out_valid_q || !out_stall_i;
    s2_adv      = s2_valid_q && (!emit || out_free);
    out_load    = s2_adv && emit;
    pop_o       = head_valid_i && (!s2_valid_q || s2_adv);
    s2_valid_d  = pop_o || (s2_valid_q && !s2_adv);
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      if (s2_adv) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_job_q <= head_job_i;
    end
    if (s2_adv) begin
      fwd_addr_q  <= s2_addr;
      fwd_entry_q <= new_entry;
    end
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a cell has at least two pixels a side, so no pixel both opens and closes it
  `ASSERT_IMPL(a_first_not_last, s2_valid_q, !(s2_job_q.first && s2_job_q.last))
  `ASSERT_NEXT(a_emit_lands, out_load, out_valid_q)
  `ASSERT_IMPL(a_emit_nonzero, out_load, new_entry.sum != '0)

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gces_pkg::*;

  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned AREA_GOAL   = 1400;
  localparam int unsigned CALM_FROM   = 1200;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH = 8'd200;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  grid_cell_error_scan DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // pixel stream and bookkeeping
  in_t pixel_q [$];
  out_t stroke_q [$];
  int unsigned pixels_sent = 0;
  int unsigned pixels_taken = 0;
  int unsigned in_area = 0;
  int unsigned strokes_seen = 0;
  int unsigned settings_used = 1;
  int unsigned mismatches = 0;
  int unsigned quiet = 0;
  logic in_beat = 1'b0;

  int unsigned in_gap = 0;
  int unsigned in_gap_odds = 4;
  int unsigned stall_left = 0;
  int unsigned out_stall_odds = 4;

  // geometry the stimulus is built against
  int unsigned gen_k = RST_CELL_SIZE;
  int unsigned gen_w = RST_WIDTH;
  int unsigned gen_h = RST_HEIGHT;
  bit col_live [DEF_MAX_CELLS_PER_ROW];

  // predictor copy of the registers and the per-column cell entries
  logic [K_W-1:0]      cfg_cell_log2 = RST_CELL_SIZE;
  logic [DIM_W-1:0]    cfg_width     = RST_WIDTH;
  logic [DIM_W-1:0]    cfg_height    = RST_HEIGHT;
  logic [THRESH_W-1:0] cfg_thresh    = RST_THRESH;
  int unsigned err_sum  [DEF_MAX_CELLS_PER_ROW];
  int unsigned peak_err [DEF_MAX_CELLS_PER_ROW];
  int unsigned peak_pos [DEF_MAX_CELLS_PER_ROW];
  int unsigned peak_rgb [DEF_MAX_CELLS_PER_ROW];

  function automatic int unsigned clamp_k(int unsigned k);
    if (k < K_MIN) return K_MIN;
    if (k > K_MAX) return K_MAX;
    return k;
  endfunction

  function automatic int unsigned sq_dist(logic [7:0] a, logic [7:0] b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // accumulate one pixel into its cell column, return 1 when the cell closes hot enough
  function automatic bit score_pixel(input in_t px, output out_t stroke);
    int unsigned k, mask, w, h, x, y, col, u, v, e, pos, rgb, s, pk, pp, pc;
    longint unsigned bar;
    stroke = '0;
    k = clamp_k(cfg_cell_log2);
    mask = (1 << k) - 1;
    w = (cfg_width > DEF_MAX_IMAGE_WIDTH) ? DEF_MAX_IMAGE_WIDTH : cfg_width;
    h = cfg_height;
    x = px.pixel_x;
    y = px.pixel_y;
    if (x >= ((w >> k) << k) || y >= ((h >> k) << k)) return 1'b0;
    col = x >> k;
    if (col >= DEF_MAX_CELLS_PER_ROW) return 1'b0;
    u = x & mask;
    v = y & mask;
    e = sq_dist(px.ref_red, px.canvas_red) + sq_dist(px.ref_green, px.canvas_green)
        + sq_dist(px.ref_blue, px.canvas_blue);
    rgb = {px.ref_red, px.ref_green, px.ref_blue};
    pos = (v << 5) | u;
    if (u == 0 && v == 0) begin
      s = e;
      pk = e;
      pp = pos;
      pc = rgb;
    end else begin
      s = (err_sum[col] + e) & 32'h0FFF_FFFF;
      pk = peak_err[col];
      pp = peak_pos[col];
      pc = peak_rgb[col];
      // ties keep the earlier pixel
      if (e > pk) begin
        pk = e;
        pp = pos;
        pc = rgb;
      end
    end
    err_sum[col]  = s;
    peak_err[col] = pk & 32'h3_FFFF;
    peak_pos[col] = pp & 32'h3FF;
    peak_rgb[col] = pc & 32'hFF_FFFF;
    if (u != mask || v != mask) return 1'b0;
    bar = cfg_thresh;
    bar = bar << (2 * k);
    if (s <= bar) return 1'b0;
    stroke.point_x        = (((x >> k) << k) + (pp & 31)) & 32'hFFF;
    stroke.point_y        = (((y >> k) << k) + ((pp >> 5) & 31)) & 32'hFFF;
    stroke.stroke_red     = pc >> 16;
    stroke.stroke_green   = pc >> 8;
    stroke.stroke_blue    = pc;
    stroke.cell_error_sum = s;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  function automatic in_t pixel(int unsigned x, int unsigned y, int unsigned rr,
                                int unsigned rg, int unsigned rb, int unsigned cr,
                                int unsigned cg, int unsigned cb);
    in_t p;
    p.pixel_x = x;
    p.pixel_y = y;
    p.ref_red = rr;
    p.ref_green = rg;
    p.ref_blue = rb;
    p.canvas_red = cr;
    p.canvas_green = cg;
    p.canvas_blue = cb;
    return p;
  endfunction

  function automatic int unsigned nudge(int unsigned c, int unsigned spread);
    int lo, hi;
    lo = int'(c) - int'(spread);
    hi = int'(c) + int'(spread);
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    return $urandom_range(lo, hi);
  endfunction

  function automatic in_t make_pixel(int unsigned x, int unsigned y, int unsigned spread);
    int unsigned r, g, b;
    r = $urandom_range(0, 255);
    g = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    return pixel(x, y, r, g, b, nudge(r, spread), nudge(g, spread), nudge(b, spread));
  endfunction

  // a column never touched since power-up must start at a top-left corner
  function automatic void queue_pixel(input in_t px);
    int unsigned col;
    if (px.pixel_x < ((gen_w >> gen_k) << gen_k) && px.pixel_y < ((gen_h >> gen_k) << gen_k))
    begin
      col = px.pixel_x >> gen_k;
      if (!col_live[col]) begin
        px.pixel_x = (px.pixel_x >> gen_k) << gen_k;
        px.pixel_y = (px.pixel_y >> gen_k) << gen_k;
        col_live[col] = 1'b1;
      end
      in_area++;
    end
    pixel_q.push_back(px);
    pixels_sent++;
  endfunction

  task automatic settle();
    do @(negedge clk_i);
    while (pixels_taken != pixels_sent || stroke_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
  endtask

  task automatic configure(int unsigned kr, int unsigned wr, int unsigned hr, int unsigned tr);
    logic [2:0]  kf;
    logic [12:0] wf, hf;
    logic [17:0] tf, junk;
    bit dirty;
    kf = kr;
    wf = wr;
    hf = hr;
    tf = tr;
    junk = $urandom;
    dirty = ($urandom_range(0, 3) == 0);
    settle();
    // upper data bits beyond a register's width must be dropped
    write_reg(CFG_CELL_SIZE, dirty ? {junk[17:3], kf} : 18'(kf));
    write_reg(CFG_WIDTH, dirty ? {junk[17:13], wf} : 18'(wf));
    write_reg(CFG_HEIGHT, dirty ? {junk[17:13], hf} : 18'(hf));
    write_reg(CFG_THRESH, tf);
    if ($urandom_range(0, 4) == 0) write_reg(CFG_NO_SUCH, junk);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    gen_k = clamp_k(kf);
    gen_w = (wf > DEF_MAX_IMAGE_WIDTH) ? DEF_MAX_IMAGE_WIDTH : wf;
    gen_h = hf;
    settings_used++;
  endtask

  // pixel driver
  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_beat)) begin
      // beat still pending
    end else if (in_gap != 0) begin
      in_gap--;
      in_valid_i <= 1'b0;
    end else if (pixel_q.size() == 0) begin
      in_valid_i <= 1'b0;
    end else if (in_gap_odds != 0 && $urandom_range(0, in_gap_odds) == 0) begin
      in_gap = $urandom_range(0, 15);
      in_valid_i <= 1'b0;
    end else begin
      in_data_i  <= pixel_q.pop_front();
      in_valid_i <= 1'b1;
    end
  end

  // downstream back-pressure
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (out_stall_odds != 0 && $urandom_range(0, out_stall_odds) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : monitor
    out_t want;
    out_t got;
    bit in_fire, out_fire, cfg_fire;
    in_fire  = in_valid_i && !in_stall_o;
    out_fire = out_valid_o && !out_stall_i;
    cfg_fire = cfg_valid_i && cfg_ready_o;
    in_beat <= in_fire;
    if (in_fire) begin
      pixels_taken++;
      if (score_pixel(in_data_i, want)) stroke_q.push_back(want);
    end
    if (out_fire) begin
      got = out_data_o;
      strokes_seen++;
      if (stroke_q.size() == 0) begin
        mismatches++;
        $display("%0t: expected no stroke, got %h", $time, got);
      end else begin
        want = stroke_q.pop_front();
        check_field("point_x", want.point_x, got.point_x);
        check_field("point_y", want.point_y, got.point_y);
        check_field("stroke_red", want.stroke_red, got.stroke_red);
        check_field("stroke_green", want.stroke_green, got.stroke_green);
        check_field("stroke_blue", want.stroke_blue, got.stroke_blue);
        check_field("cell_error_sum", want.cell_error_sum, got.cell_error_sum);
      end
    end
    if (cfg_fire) begin
      case (cfg_index_i)
        CFG_CELL_SIZE: cfg_cell_log2 = cfg_data_i[K_W-1:0];
        CFG_WIDTH:     cfg_width = cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:    cfg_height = cfg_data_i[DIM_W-1:0];
        CFG_THRESH:    cfg_thresh = cfg_data_i[THRESH_W-1:0];
        default: ;
      endcase
    end
    if (in_fire || out_fire || cfg_fire) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == STUCK_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d strokes outstanding",
                 $time, STUCK_LIMIT, stroke_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned x, y, kr, wr, hr, tr, spread, s_side, cols, rows, bx, by, phase;
    bit sparse;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: a 32x32 cell with three equal peaks, then a far-off pixel
    queue_pixel(pixel(0, 0, 255, 255, 255, 0, 0, 0));
    queue_pixel(pixel(5, 7, 0, 255, 0, 255, 0, 255));
    queue_pixel(pixel(31, 31, 255, 0, 255, 0, 255, 0));
    queue_pixel(pixel(4095, 4095, 0, 0, 0, 255, 255, 255));

    // 2x2 cells on a 5x3 image with leftover strips; first cell sits exactly on the bar
    configure(1, 5, 3, 1);
    write_reg(CFG_NO_SUCH, 18'h3FFFF);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    for (y = 0; y < 3; y++) begin
      for (x = 0; x < 5; x++) begin
        if (x == 4 || y == 2) queue_pixel(make_pixel(x, y, 255));
        else if (x == 3 && y == 1) queue_pixel(pixel(x, y, 1, 1, 0, 0, 0, 0));
        else queue_pixel(pixel(x, y, 0, 0, 1, 0, 0, 0));
      end
    end

    phase = 0;
    while (in_area < AREA_GOAL) begin
      kr = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 5) : $urandom_range(1, 3);
      if ($urandom_range(0, 11) == 0) kr = $urandom_range(0, 1) ? 0 : $urandom_range(6, 7);
      case ($urandom_range(0, 4))
        0: spread = 0;
        1: spread = 3;
        2: spread = 20;
        3: spread = 90;
        default: spread = 255;
      endcase
      case ($urandom_range(0, 5))
        0: tr = 0;
        1: tr = 195075;
        2: tr = $urandom_range(0, 262143);
        default: tr = $urandom_range(0, 2 * spread * spread + 2);
      endcase
      sparse = (clamp_k(kr) > 2) || ($urandom_range(0, 2) == 0);
      // a few fixed corners of the register space first
      if (phase == 0) begin
        kr = 1;
        tr = 0;
        sparse = 1;
      end else if (phase == 1) begin
        kr = 5;
        tr = 195075;
        sparse = 1;
      end else if (phase == 2) begin
        kr = 0;
        sparse = 0;
      end else if (phase == 3) begin
        kr = 7;
        sparse = 1;
      end
      s_side = 1 << clamp_k(kr);
      if (sparse) begin
        wr = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(1, 600);
        hr = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(1, 600);
      end else begin
        wr = $urandom_range(0, 5) * s_side + $urandom_range(0, s_side - 1);
        hr = $urandom_range(1, 3) * s_side + $urandom_range(0, s_side - 1);
      end
      if (phase == 0) wr = 8191;
      if (phase == 1) begin
        wr = 4096;
        hr = 4096;
      end
      if (phase == 3) begin
        wr = 1;
        hr = 1;
      end
      if (in_area >= CALM_FROM) begin
        in_gap_odds = 0;
        out_stall_odds = 0;
      end else begin
        in_gap_odds = $urandom_range(0, 2) * 6;
        out_stall_odds = $urandom_range(0, 2) * 6;
      end
      configure(kr, wr, hr, tr);

      if (!sparse) begin
        for (y = 0; y < gen_h; y++)
          for (x = 0; x < gen_w; x++) queue_pixel(make_pixel(x, y, spread));
      end else begin
        cols = gen_w >> gen_k;
        rows = gen_h >> gen_k;
        if (rows > (4096 >> gen_k)) rows = 4096 >> gen_k;
        repeat ($urandom_range(3, 10)) begin
          if (cols == 0 || rows == 0) begin
            queue_pixel(make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), spread));
          end else begin
            bx = $urandom_range(0, cols - 1) << gen_k;
            by = $urandom_range(0, rows - 1) << gen_k;
            // mostly whole cells; sometimes the opening or closing corner is missing
            if ($urandom_range(0, 7) != 0) queue_pixel(make_pixel(bx, by, spread));
            repeat ($urandom_range(0, 6))
              queue_pixel(make_pixel(bx + $urandom_range(0, s_side - 1),
                                     by + $urandom_range(0, s_side - 1), spread));
            if ($urandom_range(0, 7) != 0)
              queue_pixel(make_pixel(bx + s_side - 1, by + s_side - 1, spread));
            if ($urandom_range(0, 5) == 0)
              queue_pixel(make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                                     spread));
          end
        end
      end
      phase++;
    end

    settle();
    $display("pixel beats %0d, %0d of them inside whole cells, over %0d register settings",
             pixels_taken, in_area, settings_used);
    $display("strokes compared %0d, field mismatches %0d", strokes_seen, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- grid_cell_error_scan.f -----
+incdir+hw/rtl
hw/rtl/gces_pkg.sv
hw/rtl/gces_ram.sv
hw/rtl/gces_front.sv
hw/rtl/gces_queue.sv
hw/rtl/gces_back.sv
hw/rtl/grid_cell_error_scan.sv
sim/tb.sv
